// ----- rtl/lpmf_pkg.sv -----
// ---------------------------------------------------------------------------
// lpmf_pkg
// Shared widths, codes and beat types for the lidar point merge filter.
// ---------------------------------------------------------------------------
`default_nettype none

package lpmf_pkg;

    // Field widths
    localparam int COORD_BITS    = 24;
    localparam int ROT_FRAC_BITS = 16;
    localparam int COEF_BITS     = 32;
    localparam int TIME_BITS     = 32;
    localparam int OUT_TIME_BITS = TIME_BITS + 1;
    localparam int BYTE_BITS     = 8;
    localparam int BLIND_BITS    = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Transform store layout: three row-major 3x4 matrices
    localparam int AXES          = 3;
    localparam int XF_COLS       = 4;
    localparam int XF_WORDS      = AXES * XF_COLS;
    localparam int XF_COUNT      = 3;
    localparam int NUM_COEF      = XF_WORDS * XF_COUNT;
    localparam int COEF_IDX_BITS = 6;
    localparam int SLOT_BITS     = $clog2(XF_WORDS);
    localparam int NUM_PROD      = AXES * AXES;

    // Datapath widths
    localparam int PROD_BITS  = COEF_BITS + COORD_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int SHR_BITS   = SUM_BITS - ROT_FRAC_BITS;
    localparam int XF_BITS    = ((SHR_BITS > COEF_BITS) ? SHR_BITS : COEF_BITS) + 1;
    localparam int ABS_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int D2_BITS    = SQ_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t [AXES-1:0]            coord3_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef coef_t [XF_WORDS-1:0]         xform_t;
    typedef coef_t [AXES-1:0]             coef3_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef prod_t [NUM_PROD-1:0]         prod9_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [XF_BITS-1:0]    xf_t;
    typedef xf_t [AXES-1:0]               xf3_t;
    typedef logic [ABS_BITS-1:0]          abs_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef sq_t [AXES-1:0]               sq3_t;
    typedef logic [D2_BITS-1:0]           d2_t;

    localparam sum_t ROUND_HALF = sum_t'(1) <<< (ROT_FRAC_BITS - 1);

    typedef enum logic {
        REQ_POINT,
        REQ_COEF
    } req_t;

    typedef enum logic {
        SRC_LIDAR1,
        SRC_LIDAR2
    } src_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOX_ENABLE,
        REG_BOX_MIN_X,
        REG_BOX_MAX_X,
        REG_BOX_MIN_Y,
        REG_BOX_MAX_Y,
        REG_BOX_MIN_Z,
        REG_BOX_MAX_Z,
        REG_BLIND_RANGE_SQ
    } cfg_reg_t;

    typedef struct packed {
        req_t                     req_type;
        src_t                     lidar_sel;
        coord_t                   pos_x;
        coord_t                   pos_y;
        coord_t                   pos_z;
        logic [BYTE_BITS-1:0]     reflect;
        logic [BYTE_BITS-1:0]     point_tag;
        logic [BYTE_BITS-1:0]     scan_line;
        logic [TIME_BITS-1:0]     time_offset;
        logic [TIME_BITS-1:0]     frame_shift;
        logic [COEF_IDX_BITS-1:0] coef_index;
        coef_t                    coef_value;
    } in_item_t;

    typedef struct packed {
        coord_t                   out_x;
        coord_t                   out_y;
        coord_t                   out_z;
        logic [BYTE_BITS-1:0]     out_reflect;
        logic [BYTE_BITS-1:0]     out_tag;
        logic [BYTE_BITS-1:0]     out_line;
        logic [OUT_TIME_BITS-1:0] out_time;
        src_t                     out_source;
    } out_item_t;

    // Live configuration
    typedef struct packed {
        logic                  box_enable;
        coord3_t               box_lo;
        coord3_t               box_hi;
        logic [BLIND_BITS-1:0] blind_lim;
    } cfg_t;

    // Fields that ride along the pipe untouched
    typedef struct packed {
        coord3_t                  pos;
        logic [BYTE_BITS-1:0]     reflect;
        logic [BYTE_BITS-1:0]     tag;
        logic [BYTE_BITS-1:0]     line;
        logic [OUT_TIME_BITS-1:0] time_sum;
        src_t                     src;
    } meta_t;

    // Products stage
    typedef struct packed {
        meta_t  meta;
        sq3_t   sq;
        prod9_t pbox;
        prod9_t pmrg;
        coef3_t tbox;
        coef3_t tmrg;
    } prod_data_t;

    // Sums stage
    typedef struct packed {
        meta_t meta;
        d2_t   d2;
        xf3_t  qbox;
        xf3_t  qmrg;
    } sum_data_t;

endpackage

`default_nettype wire

// ----- rtl/lpmf_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// lpmf_cfg_regs
// Box bounds, box enable and blind-zone square, written over the cfg channel.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmf_cfg_regs
    import lpmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    logic                  box_enable_reg;
    coord3_t               box_lo_reg;
    coord3_t               box_hi_reg;
    logic [BLIND_BITS-1:0] blind_lim_reg;
    coord_t                wr_coord;

    assign wr_coord = coord_t'(wr_data[COORD_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_enable_reg <= 1'b1;
            box_lo_reg[0]  <= coord_t'(-1000);
            box_hi_reg[0]  <= coord_t'(2000);
            box_lo_reg[1]  <= coord_t'(-1000);
            box_hi_reg[1]  <= coord_t'(1000);
            box_lo_reg[2]  <= coord_t'(-500);
            box_hi_reg[2]  <= coord_t'(1500);
            blind_lim_reg  <= BLIND_BITS'(2500);
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_BOX_ENABLE:     box_enable_reg <= wr_data[0];
                REG_BOX_MIN_X:      box_lo_reg[0]  <= wr_coord;
                REG_BOX_MAX_X:      box_hi_reg[0]  <= wr_coord;
                REG_BOX_MIN_Y:      box_lo_reg[1]  <= wr_coord;
                REG_BOX_MAX_Y:      box_hi_reg[1]  <= wr_coord;
                REG_BOX_MIN_Z:      box_lo_reg[2]  <= wr_coord;
                REG_BOX_MAX_Z:      box_hi_reg[2]  <= wr_coord;
                REG_BLIND_RANGE_SQ: blind_lim_reg  <= wr_data[BLIND_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.box_enable = box_enable_reg;
    assign cfg.box_lo     = box_lo_reg;
    assign cfg.box_hi     = box_hi_reg;
    assign cfg.blind_lim  = blind_lim_reg;

endmodule

`default_nettype wire

// ----- rtl/lpmf_coef_bank.sv -----
// ---------------------------------------------------------------------------
// lpmf_coef_bank
// Three 3x4 transform banks plus per-bank loaded flags.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmf_coef_bank
    import lpmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [COEF_IDX_BITS-1:0] wr_index,
    input  coef_t                    wr_value,
    input  src_t                     tgt_sel,
    output xform_t                   tgt_xf,
    output xform_t                   mrg_xf,
    output logic                     all_loaded
);

    // Bank A: lidar1 to target, bank B: lidar2 to target, bank M: lidar2 to lidar1
    coef_t bank_a_reg [XF_WORDS];
    coef_t bank_b_reg [XF_WORDS];
    coef_t bank_m_reg [XF_WORDS];

    logic [XF_COUNT-1:0]      loaded_reg;
    logic [XF_COUNT-1:0]      loaded_next;
    logic                     wr_a;
    logic                     wr_b;
    logic                     wr_m;
    logic [COEF_IDX_BITS-1:0] idx_rel;
    logic [SLOT_BITS-1:0]     slot;

    always_comb
    begin
        wr_a    = 1'b0;
        wr_b    = 1'b0;
        wr_m    = 1'b0;
        idx_rel = wr_index;
        if (wr_index < COEF_IDX_BITS'(XF_WORDS))
        begin
            wr_a = wr_en;
        end
        else if (wr_index < COEF_IDX_BITS'(2 * XF_WORDS))
        begin
            wr_b    = wr_en;
            idx_rel = wr_index - COEF_IDX_BITS'(XF_WORDS);
        end
        else if (wr_index < COEF_IDX_BITS'(NUM_COEF))
        begin
            wr_m    = wr_en;
            idx_rel = wr_index - COEF_IDX_BITS'(2 * XF_WORDS);
        end
        slot        = idx_rel[SLOT_BITS-1:0];
        loaded_next = loaded_reg | {wr_m, wr_b, wr_a};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_reg <= '0;
        else
            loaded_reg <= loaded_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
            bank_a_reg[slot] <= wr_value;
        if (wr_b)
            bank_b_reg[slot] <= wr_value;
        if (wr_m)
            bank_m_reg[slot] <= wr_value;
    end

    always_comb
    begin
        for (int j = 0; j < XF_WORDS; j++)
        begin
            tgt_xf[j] = (tgt_sel == SRC_LIDAR2) ? bank_b_reg[j] : bank_a_reg[j];
            mrg_xf[j] = bank_m_reg[j];
        end
    end

    assign all_loaded = &loaded_reg;

endmodule

`default_nettype wire

// ----- rtl/lpmf_prod_stage.sv -----
// ---------------------------------------------------------------------------
// lpmf_prod_stage
// Squares for the range test and the products of both 3x3 rotations.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmf_prod_stage
    import lpmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       item_valid,
    input  in_item_t   item,
    input  logic       all_loaded,
    input  xform_t     tgt_xf,
    input  xform_t     mrg_xf,
    output logic       valid,
    output prod_data_t data
);

    logic       valid_reg;
    logic       valid_next;
    prod_data_t data_reg;
    prod_data_t data_next;
    coord3_t    pos;
    abs_t       mag;

    always_comb
    begin
        pos[0] = item.pos_x;
        pos[1] = item.pos_y;
        pos[2] = item.pos_z;
        mag    = '0;

        // Only points reach the next stage, and only once all banks are loaded
        valid_next = item_valid && (item.req_type == REQ_POINT) && all_loaded;

        data_next.meta.pos      = pos;
        data_next.meta.reflect  = item.reflect;
        data_next.meta.tag      = item.point_tag;
        data_next.meta.line     = item.scan_line;
        data_next.meta.time_sum = OUT_TIME_BITS'(item.time_offset)
                                + OUT_TIME_BITS'(item.frame_shift);
        data_next.meta.src      = item.lidar_sel;

        for (int c = 0; c < AXES; c++)
        begin
            mag = pos[c][COORD_BITS-1] ? (abs_t'(0) - abs_t'($signed(pos[c])))
                                       : abs_t'($signed(pos[c]));
            data_next.sq[c] = sq_t'(mag) * sq_t'(mag);
        end

        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                data_next.pbox[r*AXES+c] = prod_t'($signed(tgt_xf[r*XF_COLS+c]))
                                         * prod_t'($signed(pos[c]));
                data_next.pmrg[r*AXES+c] = prod_t'($signed(mrg_xf[r*XF_COLS+c]))
                                         * prod_t'($signed(pos[c]));
            end
            data_next.tbox[r] = tgt_xf[r*XF_COLS+AXES];
            data_next.tmrg[r] = mrg_xf[r*XF_COLS+AXES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/lpmf_sum_stage.sv -----
// ---------------------------------------------------------------------------
// lpmf_sum_stage
// Squared range and the rounded, translated rows of both transforms.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmf_sum_stage
    import lpmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       prev_valid,
    input  prod_data_t prev,
    output logic       valid,
    output sum_data_t  data
);

    logic      valid_reg;
    sum_data_t data_reg;
    sum_data_t data_next;
    sum_t      acc_box;
    sum_t      acc_mrg;

    always_comb
    begin
        acc_box = '0;
        acc_mrg = '0;

        data_next.meta = prev.meta;
        data_next.d2   = d2_t'(prev.sq[0]) + d2_t'(prev.sq[1]) + d2_t'(prev.sq[2]);

        // Row = floor((sum of products + half) / 2^F) + translation
        for (int r = 0; r < AXES; r++)
        begin
            acc_box = sum_t'($signed(prev.pbox[r*AXES]))
                    + sum_t'($signed(prev.pbox[r*AXES+1]))
                    + sum_t'($signed(prev.pbox[r*AXES+2]))
                    + ROUND_HALF;
            acc_mrg = sum_t'($signed(prev.pmrg[r*AXES]))
                    + sum_t'($signed(prev.pmrg[r*AXES+1]))
                    + sum_t'($signed(prev.pmrg[r*AXES+2]))
                    + ROUND_HALF;
            data_next.qbox[r] = xf_t'(acc_box >>> ROT_FRAC_BITS)
                              + xf_t'($signed(prev.tbox[r]));
            data_next.qmrg[r] = xf_t'(acc_mrg >>> ROT_FRAC_BITS)
                              + xf_t'($signed(prev.tmrg[r]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/lpmf_out_stage.sv -----
// ---------------------------------------------------------------------------
// lpmf_out_stage
// Blind-zone and box decisions, coordinate saturation, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmf_out_stage
    import lpmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      prev_valid,
    input  sum_data_t prev,
    input  cfg_t      cfg,
    output logic      valid,
    output out_item_t item
);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic coord_t sat_coord(input xf_t v);
        coord_t res;
        if (v > xf_t'(COORD_MAX))
            res = COORD_MAX;
        else if (v < xf_t'(COORD_MIN))
            res = COORD_MIN;
        else
            res = coord_t'(v);
        return res;
    endfunction

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;
    logic      in_blind;
    logic      in_box;
    coord3_t   res;

    always_comb
    begin
        in_blind = (cfg.blind_lim != '0) && (prev.d2 < d2_t'(cfg.blind_lim));

        // Inclusive box; an inverted bound pair never matches
        in_box = cfg.box_enable;
        for (int i = 0; i < AXES; i++)
        begin
            if ((prev.qbox[i] < xf_t'($signed(cfg.box_lo[i]))) ||
                (prev.qbox[i] > xf_t'($signed(cfg.box_hi[i]))))
                in_box = 1'b0;
        end

        for (int i = 0; i < AXES; i++)
        begin
            res[i] = (prev.meta.src == SRC_LIDAR2) ? sat_coord(prev.qmrg[i])
                                                   : prev.meta.pos[i];
        end

        valid_next = prev_valid && !in_blind && !in_box;

        item_next.out_x       = res[0];
        item_next.out_y       = res[1];
        item_next.out_z       = res[2];
        item_next.out_reflect = prev.meta.reflect;
        item_next.out_tag     = prev.meta.tag;
        item_next.out_line    = prev.meta.line;
        item_next.out_time    = prev.meta.time_sum;
        item_next.out_source  = prev.meta.src;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

// ----- rtl/lidar_point_merge_filter_top.sv -----
// ---------------------------------------------------------------------------
// lidar_point_merge_filter_top
// Blind-zone and crop-box filter that merges two lidar streams into the
// lidar one frame.
// ---------------------------------------------------------------------------
// One input beat per clock is taken while in_stall is low, and each point
// beat gives at most one result beat, carried through the input register,
// products, sums and result register. Throughput is one beat per cycle
// when nothing is stalled, set by the four-stage pipe; each stage holds its
// beat only while the stage after it is full and stalled, so a waiting
// result does not stop new beats until the pipe fills.
// Coefficient beats (req_type = 1) load slot coef_index of the three 3x4
// transforms (lidar1-to-target, lidar2-to-target, lidar2-to-lidar1; Q.16
// rotations, millimetre translations) and give no result; they take effect
// in stream order. Points give no result until each transform has had at
// least one write, and a point must not read a slot that was never written.
// A point is dropped when x^2+y^2+z^2 is below blind_range_sq (zero disables
// the test) or, with box_enable set, when its target-frame position lies in
// the inclusive box. Lidar two points leave in the lidar one frame, saturated
// to 24 bits; out_time is time_offset + frame_shift. Configuration writes are
// always ready and are to be made only while the pipe is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module lidar_point_merge_filter_top
    import lpmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Input beats
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_item,

    // Result beats
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_item,

    // Configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic       s1_valid_reg;
    in_item_t   s1_reg;

    logic       s2_valid;
    prod_data_t s2_data;
    logic       s3_valid;
    sum_data_t  s3_data;

    cfg_t       cfg;
    xform_t     tgt_xf;
    xform_t     mrg_xf;
    logic       all_loaded;
    logic       coef_wr;

    // Per-stage load enables: a stage takes a beat when empty or when it drains
    logic       ld_out;
    logic       ld_s3;
    logic       ld_s2;
    logic       ld_s1;

    assign ld_out   = !out_valid || !out_stall;
    assign ld_s3    = !s3_valid || ld_out;
    assign ld_s2    = !s2_valid || ld_s3;
    assign ld_s1    = !s1_valid_reg || ld_s2;
    assign in_stall = !ld_s1;

    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ld_s1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld_s1)
            s1_reg <= in_item;
    end

    // A coefficient beat writes as it leaves the input register, so points
    // ahead of it have already latched their products
    assign coef_wr = s1_valid_reg && (s1_reg.req_type == REQ_COEF) && ld_s2;

    lpmf_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lpmf_coef_bank u_coef_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (coef_wr),
        .wr_index   (s1_reg.coef_index),
        .wr_value   (s1_reg.coef_value),
        .tgt_sel    (s1_reg.lidar_sel),
        .tgt_xf     (tgt_xf),
        .mrg_xf     (mrg_xf),
        .all_loaded (all_loaded)
    );

    lpmf_prod_stage u_prod_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ld_s2),
        .item_valid (s1_valid_reg),
        .item       (s1_reg),
        .all_loaded (all_loaded),
        .tgt_xf     (tgt_xf),
        .mrg_xf     (mrg_xf),
        .valid      (s2_valid),
        .data       (s2_data)
    );

    lpmf_sum_stage u_sum_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ld_s3),
        .prev_valid (s2_valid),
        .prev       (s2_data),
        .valid      (s3_valid),
        .data       (s3_data)
    );

    lpmf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ld_out),
        .prev_valid (s3_valid),
        .prev       (s3_data),
        .cfg        (cfg),
        .valid      (out_valid),
        .item       (out_item)
    );

endmodule

`default_nettype wire
